>>> rtl/bgs_pkg.sv
// Package for the block-growth stack array: sizes, codes and the control
// record passed from the operation decoder to the top level.
// Depends on nothing.
package bgs_pkg;

  // Built depth of the element store and the widths that follow from it.
  localparam int MaxDepth = 1024;
  localparam int ElemW    = 32;
  localparam int AddrW    = $clog2(MaxDepth);
  localparam int CntW     = AddrW + 1;
  localparam int IdxW     = 10;
  localparam int CfgW     = 11;
  localparam int ApbDataW = 32;
  localparam int ApbAddrW = 3;

  // Reset values of the configuration registers.
  localparam logic [CfgW-1:0] InitCapReset   = CfgW'(16);
  localparam logic [CfgW-1:0] BlockSizeReset = CfgW'(16);

  // Register indexes, taken from byte address bit 2.
  localparam logic RegInitCap   = 1'b0;
  localparam logic RegBlockSize = 1'b1;

  typedef enum logic [1:0] {
    OpAppend = 2'd0,
    OpRemove = 2'd1,
    OpGet    = 2'd2,
    OpSet    = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StUnconf = 2'd1,
    StAlloc  = 2'd2,
    StOob    = 2'd3
  } status_e;

  // Decoded effect of one operation.
  typedef struct packed {
    status_e              status;
    logic [CntW-1:0]      next_count;
    logic [CntW-1:0]      next_cap;
    logic                 we;
    logic [AddrW-1:0]     waddr;
    logic                 re;
    logic [AddrW-1:0]     raddr;
    logic                 use_rd;
  } ctrl_t;

endpackage

>>> rtl/bgs_ctrl.sv
// Operation decoder for the block-growth stack array: works out status,
// new count and capacity, and the element store access for one operation.
// Depends on bgs_pkg.
module bgs_ctrl import bgs_pkg::*; (
  input  logic [1:0]      opcode_i,
  input  logic [IdxW-1:0] index_i,
  input  logic [CntW-1:0] count_i,
  input  logic [CntW-1:0] cap_i,
  input  logic [CfgW-1:0] init_cap_i,
  input  logic [CfgW-1:0] block_size_i,
  output ctrl_t           ctrl_o
);

  logic            unconf;
  logic            full;
  logic            grow_ok;
  logic            shrink;
  logic [CntW:0]   grown;
  logic [CntW:0]   gap;
  logic [CntW:0]   twice_bs;
  logic [CntW-1:0] cnt_dec;
  logic [CntW-1:0] shrunk;

  // Shared arithmetic for the capacity checks.
  always_comb begin
    unconf   = ((init_cap_i == '0) && (block_size_i == '0)) ||
               (init_cap_i > CfgW'(MaxDepth));
    full     = (count_i >= cap_i);
    grown    = {1'b0, cap_i} + {1'b0, block_size_i};
    grow_ok  = (block_size_i != '0) && (grown <= (CntW + 1)'(MaxDepth));
    cnt_dec  = count_i - CntW'(1);
    // A wrapped difference comes out large, as with unsigned arithmetic.
    gap      = {1'b0, cap_i} - {1'b0, cnt_dec};
    twice_bs = {block_size_i, 1'b0};
    shrink   = (block_size_i != '0) && (cap_i > init_cap_i) && (gap >= twice_bs);
    shrunk   = (cap_i - block_size_i < init_cap_i) ? init_cap_i
                                                   : cap_i - block_size_i;
  end

  // Per-operation decode.
  always_comb begin
    ctrl_o            = '0;
    ctrl_o.status     = StOk;
    ctrl_o.next_count = count_i;
    ctrl_o.next_cap   = cap_i;
    ctrl_o.waddr      = count_i[AddrW-1:0];
    ctrl_o.raddr      = index_i[AddrW-1:0];
    if (unconf) begin
      ctrl_o.status = StUnconf;
    end else begin
      unique case (opcode_e'(opcode_i))
        OpAppend: begin
          if (!full || grow_ok) begin
            // The grown capacity stands even if the store itself is full.
            if (full) begin
              ctrl_o.next_cap = grown[CntW-1:0];
            end
            if (count_i < CntW'(MaxDepth)) begin
              ctrl_o.we         = 1'b1;
              ctrl_o.next_count = count_i + CntW'(1);
            end else begin
              ctrl_o.status = StAlloc;
            end
          end else begin
            ctrl_o.status = StAlloc;
          end
        end
        OpRemove: begin
          if (count_i == '0) begin
            ctrl_o.status = StOob;
          end else begin
            ctrl_o.next_count = cnt_dec;
            ctrl_o.re         = 1'b1;
            ctrl_o.raddr      = cnt_dec[AddrW-1:0];
            ctrl_o.use_rd     = 1'b1;
            if (shrink) begin
              ctrl_o.next_cap = shrunk;
            end
          end
        end
        OpGet: begin
          if ({1'b0, index_i} >= count_i) begin
            ctrl_o.status = StOob;
          end else begin
            ctrl_o.re     = 1'b1;
            ctrl_o.use_rd = 1'b1;
          end
        end
        OpSet: begin
          if ({1'b0, index_i} >= count_i) begin
            ctrl_o.status = StOob;
          end else begin
            ctrl_o.we    = 1'b1;
            ctrl_o.waddr = index_i[AddrW-1:0];
          end
        end
      endcase
    end
  end

endmodule

>>> rtl/block_growth_stack_array_top.sv
// Top level of the block-growth stack array: configuration registers,
// counters, element store and the two-deep result path. Depends on bgs_pkg and bgs_ctrl.
//
// Path: an accepted operation passes the registered store read and the first stage,
// then the output register. Throughput: one operation per cycle while the result channel
// does not stall; the store has one write and one read port.
// Reset: registers go to 16, count to zero, capacity to 16; store contents are not cleared.
module block_growth_stack_array_top import bgs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Operation channel.
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          opcode_i,
  input  logic [IdxW-1:0]     index_i,
  input  logic [ElemW-1:0]    value_i,
  // Result channel.
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          status_o,
  output logic [ElemW-1:0]    read_value_o,
  output logic [CntW-1:0]     element_count_o,
  output logic [CntW-1:0]     current_capacity_o,
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  logic [CfgW-1:0]  init_cap_q;
  logic [CfgW-1:0]  block_size_q;
  logic [CntW-1:0]  count_q;
  logic [CntW-1:0]  cap_q;
  logic [ElemW-1:0] mem [MaxDepth];
  logic [ElemW-1:0] rdata_q;
  logic             s1_valid_q;
  status_e          s1_status_q;
  logic             s1_use_rd_q;
  logic [CntW-1:0]  s1_count_q;
  logic [CntW-1:0]  s1_cap_q;
  logic             out_valid_q;
  status_e          out_status_q;
  logic [ElemW-1:0] out_data_q;
  logic [CntW-1:0]  out_count_q;
  logic [CntW-1:0]  out_cap_q;
  logic             cfg_we;
  logic             in_accept;
  logic             s1_move;
  ctrl_t            ctrl;

  // Configuration port: always ready, register picked by address bit 2.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == RegBlockSize) ? ApbDataW'(block_size_q)
                                             : ApbDataW'(init_cap_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_cap_q   <= InitCapReset;
      block_size_q <= BlockSizeReset;
    end else if (cfg_we) begin
      if (paddr[2] == RegInitCap) begin
        init_cap_q <= pwdata[CfgW-1:0];
      end else begin
        block_size_q <= pwdata[CfgW-1:0];
      end
    end
  end

  // Handshake: the first stage frees up whenever it can move to the output.
  assign s1_move    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_move;
  assign in_accept  = in_valid_i && !in_stall_o;

  bgs_ctrl u_ctrl (
    .opcode_i     (opcode_i),
    .index_i      (index_i),
    .count_i      (count_q),
    .cap_i        (cap_q),
    .init_cap_i   (init_cap_q),
    .block_size_i (block_size_q),
    .ctrl_o       (ctrl)
  );

  // Count and capacity; a configuration write starts the stack afresh.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= CntW'(InitCapReset);
    end else if (cfg_we) begin
      count_q <= '0;
      if (paddr[2] == RegInitCap) begin
        cap_q <= pwdata[CfgW-1:0];
      end else begin
        cap_q <= init_cap_q;
      end
    end else if (in_accept) begin
      count_q <= ctrl.next_count;
      cap_q   <= ctrl.next_cap;
    end
  end

  // Element store with registered read data.
  always_ff @(posedge clk_i) begin
    if (in_accept && ctrl.we) begin
      mem[ctrl.waddr] <= value_i;
    end
    if (in_accept && ctrl.re) begin
      rdata_q <= mem[ctrl.raddr];
    end
  end

  // First stage: status and counters while the store read completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_status_q <= ctrl.status;
      s1_use_rd_q <= ctrl.use_rd;
      s1_count_q  <= (ctrl.status == StUnconf) ? '0 : ctrl.next_count;
      s1_cap_q    <= (ctrl.status == StUnconf) ? '0 : ctrl.next_cap;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_status_q <= s1_status_q;
      out_data_q   <= s1_use_rd_q ? rdata_q : '0;
      out_count_q  <= s1_count_q;
      out_cap_q    <= s1_cap_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = out_status_q;
  assign read_value_o       = out_data_q;
  assign element_count_o    = out_count_q;
  assign current_capacity_o = out_cap_q;

  // The stack never holds more elements than its capacity.
  a_count_le_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cap_q)
    else $error("element count exceeds capacity");

  // An empty first stage never stalls the input.
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> !in_stall_o)
    else $error("input stalled with an empty first stage");

  // A successful append raises the count by exactly one.
  a_append_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !cfg_we && ctrl.status == StOk && opcode_i == OpAppend)
    |=> count_q == $past(count_q) + CntW'(1))
    else $error("append did not advance the count");

  // A first-stage transaction with a free output reaches the output next cycle.
  a_stage_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_valid_q) |=> out_valid_q)
    else $error("first stage did not advance to the output");

  // Unconfigured results report zero count and capacity.
  a_unconf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == StUnconf)
    |-> (element_count_o == '0 && current_capacity_o == '0 && read_value_o == '0))
    else $error("unconfigured result carries nonzero fields");

endmodule
